FILE: sv/reig_pkg.sv
// Shared types, constants and helpers for the inverted Roberts-cross edge block.
// Used by reig_front, reig_queue, reig_back and roberts_edge_inverted_gray.
package reig_pkg;

    localparam int COORD_W     = 12;
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [COORD_W-1:0] ROW_LAST_MAX = 12'd4095;
    localparam logic [CFG_W-1:0]   HEIGHT_LIMIT = 13'd4096;
    localparam logic [COORD_W-1:0] RESET_H_M1   = 12'd479;
    localparam int                 RESET_WIDTH  = 640;

    // floor(n/3) for n <= 765 as (n * 683) >> 11
    localparam logic [9:0] DIV3_MUL = 10'd683;

    // result slots of one input word, in emission order
    localparam int RES_DIAG   = 0;
    localparam int RES_RIGHT  = 1;
    localparam int RES_BOTTOM = 2;
    localparam int RES_N      = 3;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reig_reg_t;

    typedef struct packed {
        logic [RES_N-1:0]   flags;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   diag_value;
        logic [PIX_W-1:0]   right_value;
        logic [PIX_W-1:0]   bottom_value;
    } reig_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } reig_q_status_t;

    function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] r,
                                                 input logic [PIX_W-1:0] g,
                                                 input logic [PIX_W-1:0] b);
        logic [9:0]  sum;
        logic [19:0] prod;
        sum  = 10'(r) + 10'(g) + 10'(b);
        prod = 20'(sum) * 20'(DIV3_MUL);
        return prod[18:11];
    endfunction

endpackage

FILE: sv/roberts_edge_inverted_gray.sv
// Top level of the inverted Roberts-cross edge detector on an RGB pixel stream.
// Depends on reig_pkg, reig_front, reig_queue and reig_back.
//
//  port group   dir  handshake            payload
//  s_*          in   s_valid / s_ready    s_red, s_green, s_blue
//  m_*          out  m_valid / m_ready    m_column, m_row, m_edge_value, m_last_of_run
//  cfg_*        in   cfg_wr_en (no wait)  cfg_index, cfg_data
//
//  A pixel word is taken every cycle while the result queue has room; the result
//  port sends the result words of a pixel one after another, and a pixel raises at
//  most one result word, or up to two at the end of a row above the last one and
//  up to three on the last row.
//  The first result word of a pixel passes the first stage register, the queue and
//  the output register, and is held on m_* until m_ready takes it.
//  aresetn (synchronous, active low) clears counters, window and queue; the line
//  store is not cleared, since every entry is written before its value is used.
//  Either side may stall on its own; the 4-entry queue absorbs the difference.
module roberts_edge_inverted_gray
    import reig_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [PIX_W-1:0]    s_red,
    input  logic [PIX_W-1:0]    s_green,
    input  logic [PIX_W-1:0]    s_blue,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COORD_W-1:0]  m_column,
    output logic [COORD_W-1:0]  m_row,
    output logic [PIX_W-1:0]    m_edge_value,
    output logic                m_last_of_run
);

    // front to queue
    logic           push_valid;
    reig_entry_t    push_entry;
    // queue to back
    reig_entry_t    head_entry;
    reig_q_status_t q_status;
    logic           pop;

    // accept, classify, and keep the line store and 2x2 window
    reig_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_red      (s_red),
        .s_green    (s_green),
        .s_blue     (s_blue),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .q_status   (q_status)
    );

    // hold pending result entries so the two sides stall independently
    reig_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    // send one result word per cycle while m_ready is high, marking the last of each pixel
    reig_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_entry    (head_entry),
        .q_status      (q_status),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_column      (m_column),
        .m_row         (m_row),
        .m_edge_value  (m_edge_value),
        .m_last_of_run (m_last_of_run)
    );

endmodule

FILE: sv/reig_front.sv
// Front end: accepts pixels, tracks position, holds the line store and 2x2 window,
// and turns each pixel with results into one queue entry of up to three results. Uses reig_pkg.
module reig_front
    import reig_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [PIX_W-1:0]    s_red,
    input  logic [PIX_W-1:0]    s_green,
    input  logic [PIX_W-1:0]    s_blue,
    output logic                push_valid,
    output reig_entry_t         push_entry,
    input  reig_q_status_t      q_status
);

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RESET_W = (RESET_WIDTH < MAX_WIDTH) ? RESET_WIDTH : MAX_WIDTH;
    localparam logic [CW-1:0] RESET_W_M1 = CW'(RESET_W - 1);
    localparam logic [CW-1:0] MAX_W_M1   = CW'(MAX_WIDTH - 1);

    logic [PIX_W-1:0] line_mem [MAX_WIDTH];

    logic [CW-1:0]      width_m1_reg;
    logic [COORD_W-1:0] height_m1_reg;
    logic [CW-1:0]      col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;

    logic               f1_valid_reg;
    logic [CW-1:0]      f1_col_reg;
    logic [COORD_W-1:0] f1_row_reg;
    logic [PIX_W-1:0]   f1_gray_reg;
    logic [PIX_W-1:0]   rd_reg;
    logic               byp_valid_reg;
    logic [PIX_W-1:0]   byp_data_reg;
    logic [PIX_W-1:0]   left_reg;
    logic [PIX_W-1:0]   upper_left_reg;

    logic               accept;
    logic               advance;
    logic [PIX_W-1:0]   up;
    logic [RES_N-1:0]   flags;
    logic [PIX_W-1:0]   diff_a, diff_b;
    logic [PIX_W:0]     diff_sum;
    logic [PIX_W-1:0]   diff_sat;
    logic               diag_border;
    logic [CW+COORD_W-1:0] col_ext;
    logic [CW+CFG_W-1:0]   cfg_m1_ext;
    logic [CFG_W-1:0]   cfg_m1;
    logic [CW-1:0]      cfg_w_m1;
    logic [COORD_W-1:0] cfg_h_m1;

    assign accept = s_valid && s_ready;
    assign up     = byp_valid_reg ? byp_data_reg : rd_reg;

    // classify the word held in the first stage
    always_comb begin
        flags             = '0;
        flags[RES_DIAG]   = (f1_row_reg != '0) && (f1_col_reg != '0);
        flags[RES_RIGHT]  = (f1_row_reg != '0) && (f1_col_reg == width_m1_reg);
        flags[RES_BOTTOM] = (f1_row_reg == height_m1_reg);
    end

    assign diag_border = (f1_col_reg == CW'(1)) || (f1_row_reg == COORD_W'(1));
    assign diff_a   = (upper_left_reg > f1_gray_reg) ? upper_left_reg - f1_gray_reg
                                                     : f1_gray_reg - upper_left_reg;
    assign diff_b   = (left_reg > up) ? left_reg - up : up - left_reg;
    assign diff_sum = {1'b0, diff_a} + {1'b0, diff_b};
    assign diff_sat = diff_sum[PIX_W] ? '1 : diff_sum[PIX_W-1:0];
    assign col_ext  = {{COORD_W{1'b0}}, f1_col_reg};

    always_comb begin
        push_entry.flags        = flags;
        push_entry.column       = col_ext[COORD_W-1:0];
        push_entry.row          = f1_row_reg;
        push_entry.diag_value   = diag_border ? ~upper_left_reg : ~diff_sat;
        push_entry.right_value  = ~up;
        push_entry.bottom_value = ~f1_gray_reg;
    end

    // a word with no results leaves without a queue slot
    assign advance    = f1_valid_reg && ((flags == '0) || !q_status.full);
    assign push_valid = f1_valid_reg && (flags != '0) && !q_status.full;
    assign s_ready    = !f1_valid_reg || advance;

    // position of the next pixel
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_reg == width_m1_reg) begin
            col_next = '0;
            row_next = (row_reg == height_m1_reg) ? '0 : row_reg + COORD_W'(1);
        end else begin
            col_next = col_reg + CW'(1);
        end
    end

    // clamp register writes into the supported range
    assign cfg_m1     = cfg_data - CFG_W'(1);
    assign cfg_m1_ext = {{CW{1'b0}}, cfg_m1};
    always_comb begin
        if (cfg_data == '0) begin
            cfg_w_m1 = '0;
        end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
            cfg_w_m1 = MAX_W_M1;
        end else begin
            cfg_w_m1 = cfg_m1_ext[CW-1:0];
        end
        if (cfg_data == '0) begin
            cfg_h_m1 = '0;
        end else if (cfg_data > HEIGHT_LIMIT) begin
            cfg_h_m1 = ROW_LAST_MAX;
        end else begin
            cfg_h_m1 = cfg_m1[COORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_m1_reg   <= RESET_W_M1;
            height_m1_reg  <= RESET_H_M1;
            col_reg        <= '0;
            row_reg        <= '0;
            left_reg       <= '0;
            upper_left_reg <= '0;
            f1_valid_reg   <= 1'b0;
            byp_valid_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (reig_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  width_m1_reg  <= cfg_w_m1;
                REG_FRAME_HEIGHT: height_m1_reg <= cfg_h_m1;
                default: ;
            endcase
            col_reg        <= '0;
            row_reg        <= '0;
            left_reg       <= '0;
            upper_left_reg <= '0;
        end else begin
            if (accept) begin
                col_reg       <= col_next;
                row_reg       <= row_next;
                byp_valid_reg <= advance && (f1_col_reg == col_reg);
            end
            if (advance) begin
                left_reg       <= f1_gray_reg;
                upper_left_reg <= up;
            end
            if (accept) begin
                f1_valid_reg <= 1'b1;
            end else if (advance) begin
                f1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_col_reg   <= col_reg;
            f1_row_reg   <= row_reg;
            f1_gray_reg  <= gray_of(s_red, s_green, s_blue);
            byp_data_reg <= f1_gray_reg;
        end
    end

    // line store: write the leaving word, read for the arriving one
    always_ff @(posedge aclk) begin
        if (advance) begin
            line_mem[f1_col_reg] <= f1_gray_reg;
        end
        if (accept) begin
            rd_reg <= line_mem[col_reg];
        end
    end

    a_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= width_m1_reg)
        else $error("column counter left the frame");

    a_row_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= height_m1_reg)
        else $error("row counter left the frame");

endmodule

FILE: sv/reig_queue.sv
// Short FIFO of result entries between front and back end.
// Uses reig_pkg for the entry type and depth.
module reig_queue
    import reig_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    input  reig_entry_t    push_entry,
    input  logic           pop,
    output reig_entry_t    head_entry,
    output reig_q_status_t q_status
);

    reig_entry_t         slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg, count_next;

    assign head_entry     = slots[rd_ptr_reg];
    assign q_status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

    always_comb begin
        count_next = count_reg;
        if (push_valid && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push_valid) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !q_status.full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("pop from an empty queue");

endmodule

FILE: sv/reig_back.sv
// Back end: walks the result slots of the queue head and drives the result
// channel through an output register. Uses reig_pkg.
module reig_back
    import reig_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  reig_entry_t         head_entry,
    input  reig_q_status_t      q_status,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COORD_W-1:0]  m_column,
    output logic [COORD_W-1:0]  m_row,
    output logic [PIX_W-1:0]    m_edge_value,
    output logic                m_last_of_run
);

    logic [RES_N-1:0]   done_reg, done_next;
    logic               m_valid_reg, m_valid_next;
    logic [COORD_W-1:0] column_reg, column_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [PIX_W-1:0]   value_reg, value_next;
    logic               last_reg, last_next;

    logic               head_valid;
    logic               load;
    logic [RES_N-1:0]   remaining;
    logic [RES_N-1:0]   pick;
    logic               last;

    assign head_valid = !q_status.empty;
    assign remaining  = head_entry.flags & ~done_reg;

    // lowest pending slot goes first
    always_comb begin
        pick             = '0;
        pick[RES_DIAG]   = remaining[RES_DIAG];
        pick[RES_RIGHT]  = remaining[RES_RIGHT] && !remaining[RES_DIAG];
        pick[RES_BOTTOM] = remaining[RES_BOTTOM] && !remaining[RES_RIGHT]
                           && !remaining[RES_DIAG];
    end

    assign last = ((remaining & ~pick) == '0);
    assign load = head_valid && (!m_valid_reg || m_ready);
    assign pop  = load && last;

    always_comb begin
        done_next    = done_reg;
        m_valid_next = m_valid_reg;
        column_next  = column_reg;
        row_next     = row_reg;
        value_next   = value_reg;
        last_next    = last_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
            last_next    = last;
            done_next    = last ? '0 : (done_reg | pick);
            case (pick)
                RES_N'(1 << RES_DIAG): begin
                    column_next = head_entry.column - COORD_W'(1);
                    row_next    = head_entry.row - COORD_W'(1);
                    value_next  = head_entry.diag_value;
                end
                RES_N'(1 << RES_RIGHT): begin
                    column_next = head_entry.column;
                    row_next    = head_entry.row - COORD_W'(1);
                    value_next  = head_entry.right_value;
                end
                default: begin
                    column_next = head_entry.column;
                    row_next    = head_entry.row;
                    value_next  = head_entry.bottom_value;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        column_reg <= column_next;
        row_reg    <= row_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_column      = column_reg;
    assign m_row         = row_reg;
    assign m_edge_value  = value_reg;
    assign m_last_of_run = last_reg;

    a_head_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> (remaining != '0))
        else $error("queue head has no result left to send");

    a_done_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg != '0) |-> head_valid)
        else $error("partly sent entry vanished from the queue");

endmodule

FILE: sim/tb.sv
// Self-checking bench for roberts_edge_inverted_gray: raster pixel words in, edge words out.
// Depends on reig_pkg (widths, register enum) and the RTL under sv/.
// Directed table first, then random frames; every result word is checked field by field.
module tb;
    import reig_pkg::*;

    // Cycles to let pass after the last result before a register write or the end:
    // pixels on the first row raise no word, so the pipe may still hold one.
    localparam int SETTLE_CYCLES = 8;
    // Receiver hold-off long enough to fill the 4-deep result queue and stall s_ready.
    localparam int LONG_HOLD     = 48;
    // Worst quiet stretch in a good run is the long hold plus a few gaps and the
    // settle pause; take it many times over.
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_PIXELS = 250;
    localparam int HOLD_PHASE    = 2;
    localparam int SCRIPT_LEN    = 25;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   edge_value;
        logic               last_of_run;
    } edge_word_t;

    typedef struct packed {
        logic               is_write;
        reig_reg_t          target;
        logic [CFG_W-1:0]   value;
        logic [PIX_W-1:0]   red;
        logic [PIX_W-1:0]   green;
        logic [PIX_W-1:0]   blue;
        logic               has_typed;
        logic [PIX_W-1:0]   typed_edge;
    } script_row_t;

    logic               aclk;
    logic               aresetn       = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [0:0]         cfg_index     = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]   cfg_data      = '0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [PIX_W-1:0]   s_red         = '0;
    logic [PIX_W-1:0]   s_green       = '0;
    logic [PIX_W-1:0]   s_blue        = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [COORD_W-1:0] m_column;
    logic [COORD_W-1:0] m_row;
    logic [PIX_W-1:0]   m_edge_value;
    logic               m_last_of_run;

    // Predicted frame geometry and window state
    int                 frame_w;
    int                 frame_h;
    int                 col_pos;
    int                 row_pos;
    logic [PIX_W-1:0]   gray_line [0:4095];
    logic [PIX_W-1:0]   left_gray;
    logic [PIX_W-1:0]   upper_gray;

    edge_word_t         pending_edges [$];
    script_row_t        script [0:SCRIPT_LEN-1];

    int                 mismatch_count = 0;
    int                 results_seen   = 0;
    int                 idle_cycles    = 0;
    int                 rx_wait        = 0;
    bit                 rx_calm        = 1'b0;
    bit                 tx_calm        = 1'b0;
    int                 hold_orders    = 0;
    int                 hold_served    = 0;

    roberts_edge_inverted_gray dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_column      (m_column),
        .m_row         (m_row),
        .m_edge_value  (m_edge_value),
        .m_last_of_run (m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("error: %s on result word %0d: got %0d, want %0d",
                 what, results_seen, got, want);
        mismatch_count++;
    endtask

    function automatic edge_word_t make_edge(input int c, input int r, input int v);
        edge_word_t e;
        e.column      = c[COORD_W-1:0];
        e.row         = r[COORD_W-1:0];
        e.edge_value  = v[PIX_W-1:0];
        e.last_of_run = 1'b0;
        return e;
    endfunction

    function automatic logic [PIX_W-1:0] clip_byte(input int v);
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[PIX_W-1:0];
    endfunction

    // Register write as the block sees it: clamp to the legal range, restart the frame.
    // The line store keeps its contents.
    function automatic void take_register(input reig_reg_t target, input logic [CFG_W-1:0] v);
        int n;
        n = int'(v);
        if (n == 0) n = 1;
        if (n > 4096) n = 4096;
        if (target == REG_FRAME_WIDTH) frame_w = n;
        else frame_h = n;
        col_pos    = 0;
        row_pos    = 0;
        left_gray  = '0;
        upper_gray = '0;
    endfunction

    // Work out the edge words raised by one pixel and queue them in emission order:
    // the diagonal neighbor up-left, the right border of the row above, then the
    // pixel itself on the bottom row.
    function automatic void predict_edges(input logic [PIX_W-1:0] r, g, b,
                                          input logic has_typed,
                                          input logic [PIX_W-1:0] typed_edge);
        int         gray;
        int         above;
        int         grad;
        int         n;
        edge_word_t batch [0:2];
        gray  = (int'(r) + int'(g) + int'(b)) / 3;
        above = int'(gray_line[col_pos]);
        n     = 0;
        if (row_pos >= 1 && col_pos >= 1) begin
            if (col_pos == 1 || row_pos == 1) begin
                batch[n] = make_edge(col_pos - 1, row_pos - 1, 255 - int'(upper_gray));
            end else begin
                grad = ((int'(upper_gray) > gray) ? int'(upper_gray) - gray
                                                  : gray - int'(upper_gray))
                     + ((int'(left_gray) > above) ? int'(left_gray) - above
                                                  : above - int'(left_gray));
                if (grad > 255) grad = 255;
                batch[n] = make_edge(col_pos - 1, row_pos - 1, 255 - grad);
            end
            n++;
        end
        if (row_pos >= 1 && col_pos == frame_w - 1) begin
            batch[n] = make_edge(col_pos, row_pos - 1, 255 - above);
            n++;
        end
        if (row_pos == frame_h - 1) begin
            batch[n] = make_edge(col_pos, row_pos, 255 - gray);
            n++;
        end
        if (n > 0) batch[n-1].last_of_run = 1'b1;
        // typed rows are single-word cases whose value is known by hand
        if (has_typed && n > 0) batch[0].edge_value = typed_edge;
        for (int i = 0; i < n; i++) pending_edges.push_back(batch[i]);

        gray_line[col_pos] = gray[PIX_W-1:0];
        upper_gray         = above[PIX_W-1:0];
        left_gray          = gray[PIX_W-1:0];
        if (col_pos + 1 >= frame_w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= frame_h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endfunction

    // Offer one pixel word after a random gap and hold it until accepted.
    // Valid stays high across back-to-back words, so it is never lowered and
    // raised in one step.
    task automatic send_pixel(input logic [PIX_W-1:0] r, g, b,
                              input logic has_typed, input logic [PIX_W-1:0] typed_edge);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red   <= r;
        s_green <= g;
        s_blue  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_edges(r, g, b, has_typed, typed_edge);
    endtask

    // Drop valid, wait for every pending word, then let the pipe drain.
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One write, then a quiet wait with the enable low, so back-to-back writes never
    // re-raise the enable in the step that lowers it.
    task automatic write_register(input reig_reg_t target, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= target;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        take_register(target, value);
        @(posedge aclk);
    endtask

    function automatic script_row_t write_row(input reig_reg_t target,
                                              input logic [CFG_W-1:0] value);
        script_row_t row;
        row          = '0;
        row.is_write = 1'b1;
        row.target   = target;
        row.value    = value;
        return row;
    endfunction

    function automatic script_row_t pixel_row(input logic [PIX_W-1:0] r, g, b,
                                              input int typed);
        script_row_t row;
        row            = '0;
        row.red        = r;
        row.green      = g;
        row.blue       = b;
        row.has_typed  = (typed >= 0);
        row.typed_edge = typed[PIX_W-1:0];
        return row;
    endfunction

    // Result side: check each accepted word against the oldest prediction, then
    // draw the next stall. A long hold ordered by the stimulus side is counted here.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_edges.size() == 0) begin
                    report_mismatch("word with nothing pending, edge_value",
                                    m_edge_value, -1);
                end else begin
                    edge_word_t want;
                    want = pending_edges.pop_front();
                    if (m_column !== want.column)
                        report_mismatch("column", m_column, want.column);
                    if (m_row !== want.row)
                        report_mismatch("row", m_row, want.row);
                    if (m_edge_value !== want.edge_value)
                        report_mismatch("edge_value", m_edge_value, want.edge_value);
                    if (m_last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", m_last_of_run, want.last_of_run);
                end
                results_seen++;
                // alternate stretches of free flow with stretches of random stalls
                if (results_seen % 40 == 0) rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 3);
            end
            if (hold_served != hold_orders) begin
                hold_served = hold_orders;
                rx_wait     = LONG_HOLD;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("roberts_edge_inverted_gray: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int               w_val;
        int               h_val;
        int               kind;
        int               sel;
        int               count;
        int               style;
        int               base;
        int               phase_no;
        int               random_pixels;
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;

        // Reset state of the prediction
        frame_w    = 640;
        frame_h    = 480;
        col_pos    = 0;
        row_pos    = 0;
        left_gray  = '0;
        upper_gray = '0;
        for (int i = 0; i < 4096; i++) gray_line[i] = '0;

        // Directed table. A height of zero acts as one row, so every pixel is a
        // bottom-border word whose value is 255 - gray and can be typed in.
        script[0]  = write_row(REG_FRAME_WIDTH, 13'd4);
        script[1]  = write_row(REG_FRAME_HEIGHT, 13'd0);
        script[2]  = pixel_row(8'd0, 8'd0, 8'd0, 255);
        script[3]  = pixel_row(8'd255, 8'd255, 8'd255, 0);
        script[4]  = pixel_row(8'd255, 8'd255, 8'd254, 1);
        // 4x3 checkerboard: zero gradient inside, three words per pixel at
        // the bottom-right corner
        script[5]  = write_row(REG_FRAME_HEIGHT, 13'd3);
        for (int i = 0; i < 12; i++) begin
            if ((((i % 4) + (i / 4)) % 2) == 0)
                script[6+i] = pixel_row(8'd255, 8'd255, 8'd255, -1);
            else
                script[6+i] = pixel_row(8'd0, 8'd0, 8'd0, -1);
        end
        // width above the store acts as the full store; a single row
        script[18] = write_row(REG_FRAME_WIDTH, 13'd8191);
        script[19] = write_row(REG_FRAME_HEIGHT, 13'd1);
        script[20] = pixel_row(8'd128, 8'd128, 8'd128, 127);
        // single column, tallest frame: each row closes the right border above
        script[21] = write_row(REG_FRAME_WIDTH, 13'd0);
        script[22] = write_row(REG_FRAME_HEIGHT, 13'd8191);
        script[23] = pixel_row(8'd30, 8'd60, 8'd90, -1);
        script[24] = pixel_row(8'd90, 8'd60, 8'd30, -1);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the table; settle before every write so the block is idle.
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            if (script[i].is_write) begin
                settle_idle();
                write_register(script[i].target, script[i].value);
            end else begin
                send_pixel(script[i].red, script[i].green, script[i].blue,
                           script[i].has_typed, script[i].typed_edge);
            end
        end

        // Random frames: mostly small geometries run to completion, a few partial
        // frames cut short by the next write, a few at the size extremes.
        random_pixels = 0;
        phase_no      = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            settle_idle();
            kind = (phase_no == HOLD_PHASE) ? 9 : $urandom_range(0, 9);
            case (kind)
                0: begin
                    w_val = $urandom_range(0, 1) ? 4096 : $urandom_range(4097, 8191);
                    h_val = 1;
                    sel   = $urandom_range(2, 3);
                end
                1: begin
                    w_val = $urandom_range(0, 1);
                    h_val = $urandom_range(0, 1) ? 4096 : $urandom_range(4097, 8191);
                    sel   = $urandom_range(2, 3);
                end
                2: begin
                    w_val = 2;
                    h_val = 4096;
                    sel   = $urandom_range(2, 3);
                end
                default: begin
                    w_val = $urandom_range(1, 7);
                    h_val = $urandom_range(1, 6);
                    sel   = $urandom_range(0, 3);
                end
            endcase
            if (phase_no == HOLD_PHASE) begin
                w_val = 6;
                h_val = 6;
                sel   = 3;
            end

            if (sel == 3) write_register(REG_FRAME_WIDTH, w_val[CFG_W-1:0]);
            if (sel != 0) write_register(REG_FRAME_HEIGHT, h_val[CFG_W-1:0]);
            if (sel == 0 || sel == 2) write_register(REG_FRAME_WIDTH, w_val[CFG_W-1:0]);

            if (kind < 3)
                count = $urandom_range(10, 20);
            else if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, frame_w * frame_h);
            else
                count = frame_w * frame_h * $urandom_range(1, 2);
            if (count > 48) count = 48;
            if (phase_no == HOLD_PHASE) count = 36;
            if (count > RANDOM_PIXELS - random_pixels) count = RANDOM_PIXELS - random_pixels;

            style   = (phase_no == HOLD_PHASE) ? 0 : $urandom_range(0, 3);
            tx_calm = (phase_no == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
            base    = $urandom_range(0, 255);

            for (int i = 0; i < count; i++) begin
                case (style)
                    0: begin
                        r = 8'($urandom_range(0, 255));
                        g = 8'($urandom_range(0, 255));
                        b = 8'($urandom_range(0, 255));
                    end
                    1: begin
                        // slow drift keeps the gradient below saturation
                        base = int'(clip_byte(base + int'($urandom_range(0, 16)) - 8));
                        r    = clip_byte(base + int'($urandom_range(0, 8)) - 4);
                        g    = clip_byte(base + int'($urandom_range(0, 8)) - 4);
                        b    = clip_byte(base + int'($urandom_range(0, 8)) - 4);
                    end
                    2: begin
                        r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                        g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                        b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    end
                    default: begin
                        r = 8'($urandom_range(0, 255));
                        g = r;
                        b = r;
                    end
                endcase
                // order a long hold on the result side while pixels keep coming,
                // so the queue fills and s_ready drops
                if (phase_no == HOLD_PHASE && i == 8) hold_orders++;
                // pause the sender mid-frame until every pending word is out
                if (phase_no == HOLD_PHASE && i == 24) settle_idle();
                send_pixel(r, g, b, 1'b0, 8'd0);
                random_pixels++;
            end
            phase_no++;
        end

        settle_idle();
        if (pending_edges.size() != 0)
            report_mismatch("words never delivered", 0, pending_edges.size());
        if (mismatch_count == 0)
            $display("roberts_edge_inverted_gray: match");
        else
            $display("roberts_edge_inverted_gray: mismatch");
        $finish;
    end

endmodule
